@@ hw/rtl/wigd_pkg.sv @@
// Shared constants and helper functions of the Wigner-d recurrence block.
package wigd_pkg;

    // Divider: dividend width, divisor width and step counter width.
    localparam int DIV_NW = 58;
    localparam int DIV_DW = 37;
    localparam int DIV_CW = 6;

    // Square root: radicand width, root width and step counter width.
    localparam int SQ_W  = 56;
    localparam int SQ_RW = 28;
    localparam int SQ_CW = 5;

    // Serial multiply-accumulate: coefficient width, accumulator width, counter width.
    localparam int MAC_N  = 58;
    localparam int ACC_W  = 92;
    localparam int MAC_CW = 6;

    // Degree after reset.
    localparam logic [8:0] DEG_RESET = 9'd2;

    // Clamp the degree register into the supported range.
    function automatic logic [8:0] clamp_degree(input logic [8:0] d, input logic [10:0] max_l);
        logic [8:0] res;
        res = d;
        if (d < 9'd2) begin
            res = 9'd2;
        end else if ({2'b00, d} > max_l) begin
            res = max_l[8:0];
        end
        return res;
    endfunction

    // 2^-L rounded to Q1.30.
    function automatic logic [31:0] seed_for(input logic [8:0] l);
        logic [31:0] res;
        res = 32'd0;
        if (l <= 9'd30) begin
            res = 32'd1 << 5'(9'd30 - l);
        end else if (l == 9'd31) begin
            res = 32'd1;
        end
        return res;
    endfunction

    // Negation that saturates the most negative value.
    function automatic logic [31:0] neg_sat(input logic [31:0] v);
        logic [31:0] res;
        res = (v == 32'h8000_0000) ? 32'h7FFF_FFFF : (32'd0 - v);
        return res;
    endfunction

endpackage

@@ hw/rtl/wigd_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
module wigd_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [wigd_pkg::DIV_NW-1:0]  num,
    input  logic [wigd_pkg::DIV_DW-1:0]  den,
    output logic                         done,
    output logic [wigd_pkg::DIV_NW-1:0]  quo
);
    import wigd_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [DIV_DW-1:0] den_reg, den_next;
    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;

    // One shift-and-subtract step per cycle; the dividend register fills with quotient bits.
    always_comb begin
        trial     = {rem_reg, quo_reg[DIV_NW-1]};
        diff      = trial - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end else if (busy_reg) begin
            if (!diff[DIV_DW]) begin
                rem_next = diff[DIV_DW-1:0];
                quo_next = {quo_reg[DIV_NW-2:0], 1'b1};
            end else begin
                rem_next = trial[DIV_DW-1:0];
                quo_next = {quo_reg[DIV_NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CW'(DIV_NW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

@@ hw/rtl/wigd_sqrt.sv @@
// Integer square root that produces one root bit per cycle from two radicand bits.
module wigd_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [wigd_pkg::SQ_W-1:0]   rad,
    output logic                        done,
    output logic [wigd_pkg::SQ_RW-1:0]  root
);
    import wigd_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [SQ_CW-1:0]   cnt_reg, cnt_next;
    logic [SQ_W-1:0]    rad_reg, rad_next;
    logic [SQ_RW-1:0]   root_reg, root_next;
    logic [SQ_RW+1:0]   rem_reg, rem_next;
    logic [SQ_RW+3:0]   t;
    logic [SQ_RW+4:0]   diff;

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
        t         = {rem_reg, rad_reg[SQ_W-1:SQ_W-2]};
        diff      = {1'b0, t} - {3'b000, root_reg, 2'b01};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = rad;
            root_next = '0;
            rem_next  = '0;
        end else if (busy_reg) begin
            rad_next = {rad_reg[SQ_W-3:0], 2'b00};
            if (!diff[SQ_RW+4]) begin
                rem_next  = diff[SQ_RW+1:0];
                root_next = {root_reg[SQ_RW-2:0], 1'b1};
            end else begin
                rem_next  = t[SQ_RW+1:0];
                root_next = {root_reg[SQ_RW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == SQ_CW'(SQ_RW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rad_reg  <= rad_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ hw/rtl/wigd_mac.sv @@
// Bit-serial unit that forms -(v * p1) - (w * p2), most significant coefficient bit first.
module wigd_mac (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [wigd_pkg::MAC_N-1:0]         vmag,
    input  logic [wigd_pkg::MAC_N-1:0]         wmag,
    input  logic signed [31:0]                 p1,
    input  logic signed [31:0]                 p2,
    output logic                               done,
    output logic signed [wigd_pkg::ACC_W-1:0]  acc
);
    import wigd_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [MAC_CW-1:0]       cnt_reg, cnt_next;
    logic [MAC_N-1:0]        vm_reg, vm_next;
    logic [MAC_N-1:0]        wm_reg, wm_next;
    logic signed [31:0]      p1_reg, p1_next;
    logic signed [31:0]      p2_reg, p2_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] add1, add2;

    // Double the accumulator and subtract the operands selected by the current bits.
    always_comb begin
        add1      = vm_reg[MAC_N-1] ? ACC_W'(p1_reg) : '0;
        add2      = wm_reg[MAC_N-1] ? ACC_W'(p2_reg) : '0;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        vm_next   = vm_reg;
        wm_next   = wm_reg;
        p1_next   = p1_reg;
        p2_next   = p2_reg;
        acc_next  = acc_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            vm_next   = vmag;
            wm_next   = wmag;
            p1_next   = p1;
            p2_next   = p2;
            acc_next  = '0;
        end else if (busy_reg) begin
            acc_next = (acc_reg <<< 1) - add1 - add2;
            vm_next  = {vm_reg[MAC_N-2:0], 1'b0};
            wm_next  = {wm_reg[MAC_N-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MAC_CW'(MAC_N - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        vm_reg  <= vm_next;
        wm_reg  <= wm_next;
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

@@ hw/rtl/wigner_d_half_pi_recurrence.sv @@
// Top level of the Wigner-d entry generator at beta = pi/2.
//
// The input channel (s_*) takes one transaction per matrix entry: a frame entry on
// column -L or an inner entry with the two earlier-degree values at its position.
// The result channel (m_*) returns one to four coordinate/value writes per entry;
// m_last marks the final write of an entry. An entry outside the triangle gives no
// write. The configuration channel (cfg_*) writes the degree and reseeds the frame
// product; it is always ready. The user writes it only while the block is idle, which
// the block itself does not enforce.
//
// One entry is in the block at a time. An inner entry runs two 28-step square roots,
// two 58-step divisions and a 58-step multiply-accumulate, all one bit per cycle,
// plus setup states. A frame entry runs one division, one square root and one
// multiply; the first frame entry of a column and an entry outside the triangle skip
// the arithmetic. The writes then leave at one per cycle while m_ready is high; a
// mirror copy that is not written is skipped with m_valid low. After the final write
// a new entry is taken in the next cycle. While the receiver stalls, the current
// write holds on the result ports and no new entry is accepted. Reset (aresetn low,
// synchronous) sets the degree to 2, reseeds the frame product to 2^-2 and returns
// to idle.
module wigner_d_half_pi_recurrence #(
    parameter int MAX_DEGREE = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [8:0]         cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic signed [8:0]  s_row_index,
    input  logic signed [8:0]  s_col_index,
    input  logic signed [31:0] s_prev_one,
    input  logic signed [31:0] s_prev_two,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [9:0]  m_out_row,
    output logic signed [8:0]  m_out_col,
    output logic signed [31:0] m_out_value,
    output logic               m_last
);
    import wigd_pkg::*;

    localparam logic [10:0] MAX_L = 11'(MAX_DEGREE);

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_PREP0 = 14'b00000000000010,
        ST_PREP1 = 14'b00000000000100,
        ST_SQS   = 14'b00000000001000,
        ST_SQT   = 14'b00000000010000,
        ST_DEN   = 14'b00000000100000,
        ST_DIVV  = 14'b00000001000000,
        ST_DIVW  = 14'b00000010000000,
        ST_MAC   = 14'b00000100000000,
        ST_FDIV  = 14'b00001000000000,
        ST_FSQ   = 14'b00010000000000,
        ST_FMUL  = 14'b00100000000000,
        ST_FIN   = 14'b01000000000000,
        ST_EMIT  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [8:0]  degree_reg, degree_next;
    logic [31:0] product_reg, product_next;
    logic        sq_start_reg, sq_start_next;
    logic        dv_start_reg, dv_start_next;
    logic        mac_start_reg, mac_start_next;
    logic [1:0]  idx_reg, idx_next;
    logic [3:0]  en_reg, en_next;

    logic               kind_reg, kind_next;
    logic               drop_reg, drop_next;
    logic signed [8:0]  r_reg, r_next;
    logic signed [8:0]  c_reg, c_next;
    logic signed [31:0] p1_reg, p1_next;
    logic signed [31:0] p2_reg, p2_next;
    logic [8:0]         l_reg, l_next;
    logic [8:0]         k_reg, k_next;
    logic [17:0]        a_reg, a_next, b_reg, b_next;
    logic [17:0]        a1_reg, a1_next, b1_reg, b1_next;
    logic [16:0]        rc_reg, rc_next;
    logic [35:0]        cd_reg, cd_next, ab_reg, ab_next;
    logic [26:0]        vprod_reg, vprod_next;
    logic [SQ_RW-1:0]   s_reg, s_next, t_reg, t_next;
    logic [DIV_DW-1:0]  den_reg, den_next, wprod_reg, wprod_next;
    logic [MAC_N-1:0]   vmag_reg, vmag_next, wmag_reg, wmag_next;
    logic [59:0]        fmul_reg, fmul_next;
    logic [9:0]         row_reg [4];
    logic [9:0]         row_next [4];
    logic [8:0]         col_reg [4];
    logic [8:0]         col_next [4];
    logic [31:0]        val_reg [4];
    logic [31:0]        val_next [4];

    // Shared arithmetic units.
    logic                    sq_done, dv_done, mac_done;
    logic [SQ_W-1:0]         sq_rad;
    logic [SQ_RW-1:0]        sq_root;
    logic [DIV_NW-1:0]       dv_num, dv_quo;
    logic [DIV_DW-1:0]       dv_den;
    logic signed [ACC_W-1:0] mac_acc;

    // Working values of the control logic.
    logic [8:0]              l_in;
    logic signed [10:0]      rs_in, cs_in, ls_in, ks_in;
    logic [8:0]              rr, cc, l1;
    logic signed [10:0]      rs, cs, ls, ks;
    logic [40:0]             np_full;
    logic [31:0]             pval, ival;
    logic signed [ACC_W-1:0] acc_rnd;
    logic [ACC_W-52:0]       acc_hi;
    logic                    last_w;

    wigd_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start_reg),
        .rad     (sq_rad),
        .done    (sq_done),
        .root    (sq_root)
    );

    wigd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dv_start_reg),
        .num     (dv_num),
        .den     (dv_den),
        .done    (dv_done),
        .quo     (dv_quo)
    );

    wigd_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mac_start_reg),
        .vmag    (vmag_reg),
        .wmag    (wmag_reg),
        .p1      (p1_reg),
        .p2      (p2_reg),
        .done    (mac_done),
        .acc     (mac_acc)
    );

    // Operand selection for the shared root and divider units.
    always_comb begin
        sq_rad = SQ_W'(dv_quo);
        dv_num = DIV_NW'({10'(({1'b0, l_reg, 1'b1}) - {1'b0, k_reg}), 40'd0});
        dv_den = DIV_DW'(k_reg);
        if (state_reg == ST_SQS) begin
            sq_rad = {cd_reg, 20'd0};
        end else if (state_reg == ST_SQT) begin
            sq_rad = {ab_reg, 20'd0};
        end
        if (state_reg == ST_DIVV) begin
            dv_num = DIV_NW'({vprod_reg, 30'd0}) + DIV_NW'(den_reg >> 1);
            dv_den = den_reg;
        end else if (state_reg == ST_DIVW) begin
            dv_num = DIV_NW'({wprod_reg, 20'd0}) + DIV_NW'(den_reg >> 1);
            dv_den = den_reg;
        end
    end

    // Input position checks against the current degree.
    always_comb begin
        l_in  = clamp_degree(degree_reg, MAX_L);
        rs_in = 11'(s_row_index);
        cs_in = 11'(s_col_index);
        ls_in = signed'({2'b00, l_in});
        ks_in = rs_in + ls_in;
    end

    // Values used while the entry is worked on.
    always_comb begin
        rr      = 9'(-r_reg);
        cc      = 9'(-c_reg);
        l1      = l_reg - 9'd1;
        rs      = 11'(r_reg);
        cs      = 11'(c_reg);
        ls      = signed'({2'b00, l_reg});
        ks      = signed'({2'b00, k_reg});
        np_full = 41'((fmul_reg + 60'd524288) >> 20);
        if (k_reg == 9'd0) begin
            pval = seed_for(l_reg);
        end else if (np_full > 41'h0_7FFF_FFFF) begin
            pval = 32'h7FFF_FFFF;
        end else begin
            pval = np_full[31:0];
        end
        // Round to nearest at bit 20, ties upward, then saturate to 32 bits.
        acc_rnd = mac_acc + ACC_W'(20'd524288);
        acc_hi  = acc_rnd[ACC_W-1:51];
        if ((&acc_hi) || !(|acc_hi)) begin
            ival = acc_rnd[51:20];
        end else begin
            ival = acc_rnd[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    // The final write of an entry is the last enabled slot.
    always_comb begin
        case (idx_reg)
            2'd0:    last_w = !(|en_reg[3:1]);
            2'd1:    last_w = !(|en_reg[3:2]);
            2'd2:    last_w = !en_reg[3];
            default: last_w = 1'b1;
        endcase
    end

    // Sequencer and datapath registers.
    always_comb begin
        state_next     = state_reg;
        degree_next    = degree_reg;
        product_next   = product_reg;
        sq_start_next  = 1'b0;
        dv_start_next  = 1'b0;
        mac_start_next = 1'b0;
        idx_next       = idx_reg;
        en_next        = en_reg;
        kind_next      = kind_reg;
        drop_next      = drop_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        l_next         = l_reg;
        k_next         = k_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        a1_next        = a1_reg;
        b1_next        = b1_reg;
        rc_next        = rc_reg;
        cd_next        = cd_reg;
        ab_next        = ab_reg;
        vprod_next     = vprod_reg;
        s_next         = s_reg;
        t_next         = t_reg;
        den_next       = den_reg;
        wprod_next     = wprod_reg;
        vmag_next      = vmag_reg;
        wmag_next      = wmag_reg;
        fmul_next      = fmul_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        val_next       = val_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next = s_kind;
                    r_next    = s_row_index;
                    c_next    = s_col_index;
                    p1_next   = s_prev_one;
                    p2_next   = s_prev_two;
                    l_next    = l_in;
                    k_next    = ks_in[8:0];
                    drop_next = 1'b0;
                    if (!s_kind) begin
                        if (ks_in < 11'sd0 || ks_in > ls_in) begin
                            drop_next  = 1'b1;
                            state_next = ST_FIN;
                        end else if (ks_in == 11'sd0) begin
                            state_next = ST_FIN;
                        end else begin
                            dv_start_next = 1'b1;
                            state_next    = ST_FDIV;
                        end
                    end else if (cs_in < 11'sd1 - ls_in || cs_in > rs_in || rs_in > 11'sd0) begin
                        drop_next  = 1'b1;
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_PREP0;
                    end
                end
            end
            ST_PREP0: begin
                a_next     = 18'(l_reg) * 18'(l_reg) - 18'(rr) * 18'(rr);
                b_next     = 18'(l_reg) * 18'(l_reg) - 18'(cc) * 18'(cc);
                a1_next    = 18'(l1) * 18'(l1) - 18'(rr) * 18'(rr);
                b1_next    = 18'(l1) * 18'(l1) - 18'(cc) * 18'(cc);
                rc_next    = 17'(18'(rr) * 18'(cc));
                state_next = ST_PREP1;
            end
            ST_PREP1: begin
                cd_next       = 36'(a_reg) * 36'(b_reg);
                ab_next       = 36'(a1_reg) * 36'(b1_reg);
                vprod_next    = 27'({l_reg, 1'b0} - 10'd1) * 27'(rc_reg);
                sq_start_next = 1'b1;
                state_next    = ST_SQS;
            end
            ST_SQS: begin
                if (sq_done) begin
                    s_next        = sq_root;
                    sq_start_next = 1'b1;
                    state_next    = ST_SQT;
                end
            end
            ST_SQT: begin
                if (sq_done) begin
                    t_next     = sq_root;
                    state_next = ST_DEN;
                end
            end
            ST_DEN: begin
                den_next      = DIV_DW'(l1) * DIV_DW'(s_reg);
                wprod_next    = DIV_DW'(l_reg) * DIV_DW'(t_reg);
                dv_start_next = 1'b1;
                state_next    = ST_DIVV;
            end
            ST_DIVV: begin
                if (dv_done) begin
                    vmag_next     = dv_quo;
                    dv_start_next = 1'b1;
                    state_next    = ST_DIVW;
                end
            end
            ST_DIVW: begin
                if (dv_done) begin
                    wmag_next      = dv_quo;
                    mac_start_next = 1'b1;
                    state_next     = ST_MAC;
                end
            end
            ST_MAC: begin
                if (mac_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FDIV: begin
                if (dv_done) begin
                    sq_start_next = 1'b1;
                    state_next    = ST_FSQ;
                end
            end
            ST_FSQ: begin
                if (sq_done) begin
                    state_next = ST_FMUL;
                end
            end
            ST_FMUL: begin
                fmul_next  = 60'(product_reg) * 60'(sq_root);
                state_next = ST_FIN;
            end
            ST_FIN: begin
                idx_next = 2'd0;
                if (drop_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_EMIT;
                    if (!kind_reg) begin
                        // Frame entry: the product moves on and the column is mirrored.
                        product_next = pval;
                        if (k_reg == 9'd0) begin
                            en_next     = 4'b0011;
                            row_next[0] = 10'(-ls);
                            col_next[0] = 9'(-ls);
                            val_next[0] = pval;
                            row_next[1] = 10'(ls);
                            col_next[1] = 9'(-ls);
                            val_next[1] = l_reg[0] ? neg_sat(pval) : pval;
                        end else begin
                            en_next     = 4'b1111;
                            row_next[0] = 10'(rs);
                            col_next[0] = 9'(-ls);
                            val_next[0] = pval;
                            row_next[1] = 10'(-ls);
                            col_next[1] = 9'(ks - ls);
                            val_next[1] = k_reg[0] ? neg_sat(pval) : pval;
                            row_next[2] = 10'(ls - ks);
                            col_next[2] = 9'(-ls);
                            val_next[2] = (l_reg[0] ^ k_reg[0]) ? neg_sat(pval) : pval;
                            row_next[3] = 10'(ls);
                            col_next[3] = 9'(ks - ls);
                            val_next[3] = l_reg[0] ? neg_sat(pval) : pval;
                        end
                    end else begin
                        // Inner entry and its symmetric copies.
                        en_next[0]  = 1'b1;
                        en_next[1]  = (r_reg != c_reg);
                        en_next[2]  = (rs + cs) != 11'sd0;
                        en_next[3]  = (r_reg != 9'sd0) && (r_reg != c_reg);
                        row_next[0] = 10'(rs);
                        col_next[0] = 9'(cs);
                        val_next[0] = ival;
                        row_next[1] = 10'(cs);
                        col_next[1] = 9'(rs);
                        val_next[1] = (r_reg[0] ^ c_reg[0]) ? neg_sat(ival) : ival;
                        row_next[2] = 10'(-cs);
                        col_next[2] = 9'(rs);
                        val_next[2] = l_reg[0] ? neg_sat(ival) : ival;
                        row_next[3] = 10'(-rs);
                        col_next[3] = 9'(cs);
                        val_next[3] = (l_reg[0] ^ r_reg[0] ^ c_reg[0]) ? neg_sat(ival) : ival;
                    end
                end
            end
            ST_EMIT: begin
                if (!en_reg[idx_reg]) begin
                    idx_next = idx_reg + 2'd1;
                end else if (m_ready) begin
                    if (last_w) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A degree write reseeds the frame product.
        if (cfg_valid) begin
            degree_next  = cfg_data;
            product_next = seed_for(clamp_degree(cfg_data, MAX_L));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            degree_reg    <= DEG_RESET;
            product_reg   <= seed_for(clamp_degree(DEG_RESET, MAX_L));
            sq_start_reg  <= 1'b0;
            dv_start_reg  <= 1'b0;
            mac_start_reg <= 1'b0;
            idx_reg       <= 2'd0;
            en_reg        <= 4'd0;
        end else begin
            state_reg     <= state_next;
            degree_reg    <= degree_next;
            product_reg   <= product_next;
            sq_start_reg  <= sq_start_next;
            dv_start_reg  <= dv_start_next;
            mac_start_reg <= mac_start_next;
            idx_reg       <= idx_next;
            en_reg        <= en_next;
        end
        kind_reg  <= kind_next;
        drop_reg  <= drop_next;
        r_reg     <= r_next;
        c_reg     <= c_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        l_reg     <= l_next;
        k_reg     <= k_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        a1_reg    <= a1_next;
        b1_reg    <= b1_next;
        rc_reg    <= rc_next;
        cd_reg    <= cd_next;
        ab_reg    <= ab_next;
        vprod_reg <= vprod_next;
        s_reg     <= s_next;
        t_reg     <= t_next;
        den_reg   <= den_next;
        wprod_reg <= wprod_next;
        vmag_reg  <= vmag_next;
        wmag_reg  <= wmag_next;
        fmul_reg  <= fmul_next;
        row_reg   <= row_next;
        col_reg   <= col_next;
        val_reg   <= val_next;
    end

    // Port drive.
    assign cfg_ready   = 1'b1;
    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = (state_reg == ST_EMIT) && en_reg[idx_reg];
    assign m_out_row   = row_reg[idx_reg];
    assign m_out_col   = col_reg[idx_reg];
    assign m_out_value = val_reg[idx_reg];
    assign m_last      = last_w;

endmodule

@@ hw/rtl/wigd_checker.sv @@
// Port-level checker of the Wigner-d recurrence block and its bind statement.
module wigd_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [9:0]  m_out_row,
    input logic signed [8:0]  m_out_col,
    input logic signed [31:0] m_out_value,
    input logic               m_last
);

    // A stalled write holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_row) && $stable(m_out_col)
            && $stable(m_out_value) && $stable(m_last))
        else $error("stalled write changed");

    // Only one entry is in the block at a time.
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second entry accepted while busy");

    // No entry is taken while writes are pending.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while writes pending");

    // The final write of an entry ends the burst.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> !m_valid)
        else $error("write after final write");

    // Reset clears any pending write.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("write pending after reset");

endmodule

bind wigner_d_half_pi_recurrence wigd_checker u_wigd_checker (.*);
